/* rtl/tcgr_pkg.sv */
package tcgr_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int STORE_AW    = 12;

  localparam logic [1:0] OP_PUT_CHAR    = 2'd0;
  localparam logic [1:0] OP_PUT_AT      = 2'd1;
  localparam logic [1:0] OP_CLEAR       = 2'd2;
  localparam logic [1:0] OP_LOAD_FONT   = 2'd3;

  localparam logic [1:0] CMD_FILL_CELL   = 2'd0;
  localparam logic [1:0] CMD_GLYPH_ROW   = 2'd1;
  localparam logic [1:0] CMD_SCROLL      = 2'd2;
  localparam logic [1:0] CMD_FILL_SCREEN = 2'd3;

  localparam logic [15:0] CH_BACKSPACE = 16'd8;
  localparam logic [15:0] CH_TAB       = 16'd9;
  localparam logic [15:0] CH_LINE_FEED = 16'd10;
  localparam logic [15:0] CH_RETURN    = 16'd13;

  localparam logic [2:0] REG_FORE_COLOR   = 3'd0;
  localparam logic [2:0] REG_BACK_COLOR   = 3'd1;
  localparam logic [2:0] REG_SCREEN_COLOR = 3'd2;
  localparam logic [2:0] REG_COLUMNS      = 3'd3;
  localparam logic [2:0] REG_ROWS         = 3'd4;
  localparam logic [2:0] REG_GLYPH_COUNT  = 3'd5;

  localparam logic [31:0] FORE_COLOR_RESET   = 32'h00FF_FFFF;
  localparam logic [31:0] BACK_COLOR_RESET   = 32'h0000_0000;
  localparam logic [31:0] SCREEN_COLOR_RESET = 32'h0000_0000;
  localparam logic [9:0]  COLUMNS_RESET      = 10'd128;
  localparam logic [8:0]  ROWS_RESET         = 9'd48;
  localparam logic [8:0]  GLYPH_COUNT_RESET  = 9'd256;

  localparam logic [9:0] MAX_COLUMNS = 10'd512;
  localparam logic [8:0] MAX_ROWS    = 9'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_GLYPH,
    ST_SCROLL,
    ST_CURSOR,
    ST_FILL
  } state_t;

endpackage

/* rtl/text_console_glyph_renderer_core.sv */
// Text console glyph renderer.
// Input words on in_* carry an opcode: put a character at the text position,
// put a character at a given position, clear the screen, or load one byte of
// the glyph store. Each accepted word turns into zero or more drawing command
// words on out_*, the last of them flagged by out_last_of_run. Colors and the
// screen geometry sit in registers behind the APB port.
// A printed glyph is sent as one cursor erase, one glyph row per cycle while out_ready
// is high, an optional scroll and the cursor draw, all through one output register.
// Tab, line feed, return and backspace send the cursor erase, an optional scroll and
// the cursor draw; a clear screen sends one fill-screen command and a font byte load
// none. One command leaves per cycle while out_ready is high, as set by the single
// output register and the one read port of the glyph store, which is read one row
// ahead of the row being sent.
// in_ready is high only while the sequencer is idle; the output register may
// still hold the last command then. When out_ready is low the sequencer holds
// its command and position until the word is taken.
// Reset restores the register defaults and puts text and cursor at 0,0. The
// glyph store is not cleared and must be loaded before glyphs are drawn.
module text_console_glyph_renderer_core #(
  parameter int FONT_WIDTH  = 8,
  parameter int CELL_HEIGHT = 16,
  parameter int MAX_GLYPHS  = 256,
  parameter int TAB_STEP    = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_char_code,
  input  logic [8:0]  in_target_col,
  input  logic [7:0]  in_target_row,
  input  logic [11:0] in_font_addr,
  input  logic [7:0]  in_font_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_command_kind,
  output logic [11:0] out_pixel_x,
  output logic [11:0] out_pixel_y,
  output logic [7:0]  out_row_bits,
  output logic [31:0] out_fill_color,
  output logic [31:0] out_back_color,
  output logic        out_last_of_run,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LINE_W  = (CELL_HEIGHT > 1) ? $clog2(CELL_HEIGHT) : 1;
  localparam int GLYPH_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(CELL_HEIGHT - 1);
  localparam logic [15:0] MASK_WIDE = 16'h00FF << (8 - FONT_WIDTH);
  localparam logic [7:0]  ROW_MASK  = MASK_WIDE[7:0];

  // Configuration registers.
  logic [31:0] fore_color_r;
  logic [31:0] back_color_r;
  logic [31:0] screen_color_r;
  logic [9:0]  columns_r;
  logic [8:0]  rows_r;
  logic [8:0]  glyph_count_r;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_color_r   <= tcgr_pkg::FORE_COLOR_RESET;
      back_color_r   <= tcgr_pkg::BACK_COLOR_RESET;
      screen_color_r <= tcgr_pkg::SCREEN_COLOR_RESET;
      columns_r      <= tcgr_pkg::COLUMNS_RESET;
      rows_r         <= tcgr_pkg::ROWS_RESET;
      glyph_count_r  <= tcgr_pkg::GLYPH_COUNT_RESET;
    end else if (cfg_write) begin
      case (paddr[4:2])
        tcgr_pkg::REG_FORE_COLOR:   fore_color_r   <= pwdata;
        tcgr_pkg::REG_BACK_COLOR:   back_color_r   <= pwdata;
        tcgr_pkg::REG_SCREEN_COLOR: screen_color_r <= pwdata;
        tcgr_pkg::REG_COLUMNS:      columns_r      <= pwdata[9:0];
        tcgr_pkg::REG_ROWS:         rows_r         <= pwdata[8:0];
        tcgr_pkg::REG_GLYPH_COUNT:  glyph_count_r  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      tcgr_pkg::REG_FORE_COLOR:   prdata = fore_color_r;
      tcgr_pkg::REG_BACK_COLOR:   prdata = back_color_r;
      tcgr_pkg::REG_SCREEN_COLOR: prdata = screen_color_r;
      tcgr_pkg::REG_COLUMNS:      prdata = {22'd0, columns_r};
      tcgr_pkg::REG_ROWS:         prdata = {23'd0, rows_r};
      tcgr_pkg::REG_GLYPH_COUNT:  prdata = {23'd0, glyph_count_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // Effective geometry and glyph limit.
  logic [9:0]         cols_used;
  logic [9:0]         cols_m1;
  logic [8:0]         rows_used;
  logic [8:0]         rows_m1;
  logic [9:0]         glyph_limit;
  logic [GLYPH_W-1:0] glyph_sel;
  logic [11:0]        glyph_base;

  always_comb begin
    if (columns_r == 10'd0) begin
      cols_used = 10'd1;
    end else if (columns_r > tcgr_pkg::MAX_COLUMNS) begin
      cols_used = tcgr_pkg::MAX_COLUMNS;
    end else begin
      cols_used = columns_r;
    end
    if (rows_r == 9'd0) begin
      rows_used = 9'd1;
    end else if (rows_r > tcgr_pkg::MAX_ROWS) begin
      rows_used = tcgr_pkg::MAX_ROWS;
    end else begin
      rows_used = rows_r;
    end
    cols_m1 = cols_used - 10'd1;
    rows_m1 = rows_used - 9'd1;
    if ({1'b0, glyph_count_r} < 10'(MAX_GLYPHS)) begin
      glyph_limit = {1'b0, glyph_count_r};
    end else begin
      glyph_limit = 10'(MAX_GLYPHS);
    end
    if (in_char_code < {6'd0, glyph_limit}) begin
      glyph_sel = in_char_code[GLYPH_W-1:0];
    end else begin
      glyph_sel = '0;
    end
    glyph_base = 12'(glyph_sel * CELL_HEIGHT);
  end

  // Sequencer state and positions.
  tcgr_pkg::state_t  state_r, state_nxt;
  logic [8:0]        text_col_r, text_col_nxt;
  logic [7:0]        text_row_r, text_row_nxt;
  logic [8:0]        cur_col_r, cur_col_nxt;
  logic [7:0]        cur_row_r, cur_row_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [15:0]       char_r, char_nxt;
  logic [11:0]       base_r, base_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [11:0] x_r, x_nxt;
  logic [11:0] y_r, y_nxt;
  logic [7:0]  bits_r, bits_nxt;
  logic [31:0] fill_r, fill_nxt;
  logic [31:0] back_r, back_nxt;
  logic        last_r, last_nxt;

  // Command being offered by the sequencer.
  logic        emit_req;
  logic        emit_go;
  logic [1:0]  cmd_kind;
  logic [11:0] cmd_x;
  logic [11:0] cmd_y;
  logic [7:0]  cmd_bits;
  logic [31:0] cmd_fill;
  logic [31:0] cmd_back;
  logic        cmd_last;

  // Glyph store.
  logic [7:0]          font_mem [tcgr_pkg::STORE_DEPTH];
  logic [7:0]          rdata_r;
  logic                mem_we;
  logic [tcgr_pkg::STORE_AW-1:0] rd_addr;

  logic [8:0] row_inc;
  logic       need_scroll;
  logic [9:0] tab_sum;
  logic [9:0] tab_diff;
  logic [8:0] tab_wrap;

  assign in_ready = (state_r == tcgr_pkg::ST_IDLE);
  assign mem_we   = in_ready && in_valid && (in_opcode == tcgr_pkg::OP_LOAD_FONT);
  assign emit_go  = !out_valid_r || out_ready;

  always_comb begin
    row_inc     = {1'b0, text_row_r} + 9'd1;
    need_scroll = (row_inc >= rows_used);
    tab_sum     = {1'b0, text_col_r} + 10'(TAB_STEP);
    tab_diff    = tab_sum - cols_m1;
    tab_wrap    = (tab_diff > cols_m1) ? cols_m1[8:0] : tab_diff[8:0];
  end

  always_comb begin
    state_nxt    = state_r;
    text_col_nxt = text_col_r;
    text_row_nxt = text_row_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    line_nxt     = '0;
    char_nxt     = char_r;
    base_nxt     = base_r;
    emit_req     = 1'b0;
    cmd_kind     = tcgr_pkg::CMD_FILL_CELL;
    cmd_x        = 12'(cur_col_r * FONT_WIDTH);
    cmd_y        = 12'(cur_row_r * CELL_HEIGHT);
    cmd_bits     = 8'd0;
    cmd_fill     = screen_color_r;
    cmd_back     = 32'd0;
    cmd_last     = 1'b0;

    case (state_r)
      tcgr_pkg::ST_IDLE: begin
        if (in_valid) begin
          char_nxt = in_char_code;
          base_nxt = glyph_base;
          case (in_opcode)
            tcgr_pkg::OP_PUT_CHAR: begin
              state_nxt = tcgr_pkg::ST_CLEAR;
            end
            tcgr_pkg::OP_PUT_AT: begin
              if (({1'b0, in_target_col} < cols_used) &&
                  ({1'b0, in_target_row} < rows_used)) begin
                text_col_nxt = in_target_col;
                text_row_nxt = in_target_row;
                state_nxt    = tcgr_pkg::ST_CLEAR;
              end
            end
            tcgr_pkg::OP_CLEAR: begin
              text_col_nxt = 9'd0;
              text_row_nxt = 8'd0;
              state_nxt    = tcgr_pkg::ST_FILL;
            end
            default: ;
          endcase
        end
      end

      tcgr_pkg::ST_CLEAR: begin
        emit_req = 1'b1;
        if (emit_go) begin
          case (char_r)
            tcgr_pkg::CH_TAB: begin
              if (tab_sum > cols_m1) begin
                text_col_nxt = tab_wrap;
                text_row_nxt = row_inc[7:0];
                cur_col_nxt  = tab_wrap;
                cur_row_nxt  = row_inc[7:0];
                state_nxt    = need_scroll ? tcgr_pkg::ST_SCROLL : tcgr_pkg::ST_CURSOR;
              end else begin
                text_col_nxt = tab_sum[8:0];
                cur_col_nxt  = tab_sum[8:0];
                cur_row_nxt  = text_row_r;
                state_nxt    = tcgr_pkg::ST_CURSOR;
              end
            end
            tcgr_pkg::CH_LINE_FEED: begin
              text_col_nxt = 9'd0;
              text_row_nxt = row_inc[7:0];
              cur_col_nxt  = 9'd0;
              cur_row_nxt  = row_inc[7:0];
              state_nxt    = need_scroll ? tcgr_pkg::ST_SCROLL : tcgr_pkg::ST_CURSOR;
            end
            tcgr_pkg::CH_RETURN: begin
              text_col_nxt = 9'd0;
              cur_col_nxt  = 9'd0;
              cur_row_nxt  = text_row_r;
              state_nxt    = tcgr_pkg::ST_CURSOR;
            end
            tcgr_pkg::CH_BACKSPACE: begin
              if (cur_col_r == 9'd0) begin
                cur_col_nxt = cols_m1[8:0];
                cur_row_nxt = (cur_row_r != 8'd0) ? cur_row_r - 8'd1 : cur_row_r;
              end else begin
                cur_col_nxt = cur_col_r - 9'd1;
              end
              if (text_col_r == 9'd0) begin
                text_col_nxt = cols_m1[8:0];
                text_row_nxt = (text_row_r != 8'd0) ? text_row_r - 8'd1 : text_row_r;
              end else begin
                text_col_nxt = text_col_r - 9'd1;
              end
              state_nxt = tcgr_pkg::ST_CURSOR;
            end
            default: begin
              state_nxt = tcgr_pkg::ST_GLYPH;
            end
          endcase
        end
      end

      tcgr_pkg::ST_GLYPH: begin
        emit_req = 1'b1;
        cmd_kind = tcgr_pkg::CMD_GLYPH_ROW;
        cmd_x    = 12'(text_col_r * FONT_WIDTH);
        cmd_y    = 12'(text_row_r * CELL_HEIGHT + line_r);
        cmd_bits = rdata_r & ROW_MASK;
        cmd_fill = fore_color_r;
        cmd_back = back_color_r;
        line_nxt = line_r;
        if (emit_go) begin
          if (line_r == LAST_LINE) begin
            if ({1'b0, text_col_r} < cols_m1) begin
              text_col_nxt = text_col_r + 9'd1;
              cur_col_nxt  = text_col_r + 9'd1;
              cur_row_nxt  = text_row_r;
              state_nxt    = tcgr_pkg::ST_CURSOR;
            end else begin
              text_col_nxt = 9'd0;
              text_row_nxt = row_inc[7:0];
              cur_col_nxt  = 9'd0;
              cur_row_nxt  = row_inc[7:0];
              state_nxt    = need_scroll ? tcgr_pkg::ST_SCROLL : tcgr_pkg::ST_CURSOR;
            end
          end else begin
            line_nxt = line_r + LINE_W'(1);
          end
        end
      end

      tcgr_pkg::ST_SCROLL: begin
        emit_req = 1'b1;
        cmd_kind = tcgr_pkg::CMD_SCROLL;
        cmd_x    = 12'd0;
        cmd_y    = 12'd0;
        cmd_fill = 32'd0;
        cmd_back = screen_color_r;
        if (emit_go) begin
          text_col_nxt = 9'd0;
          text_row_nxt = rows_m1[7:0];
          cur_col_nxt  = 9'd0;
          cur_row_nxt  = rows_m1[7:0];
          state_nxt    = tcgr_pkg::ST_CURSOR;
        end
      end

      tcgr_pkg::ST_CURSOR: begin
        emit_req = 1'b1;
        cmd_fill = fore_color_r;
        cmd_last = 1'b1;
        if (emit_go) begin
          state_nxt = tcgr_pkg::ST_IDLE;
        end
      end

      tcgr_pkg::ST_FILL: begin
        emit_req = 1'b1;
        cmd_kind = tcgr_pkg::CMD_FILL_SCREEN;
        cmd_x    = 12'd0;
        cmd_y    = 12'd0;
        cmd_last = 1'b1;
        if (emit_go) begin
          state_nxt = tcgr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tcgr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    bits_nxt      = bits_r;
    fill_nxt      = fill_r;
    back_nxt      = back_r;
    last_nxt      = last_r;
    if (emit_req && emit_go) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = cmd_kind;
      x_nxt         = cmd_x;
      y_nxt         = cmd_y;
      bits_nxt      = cmd_bits;
      fill_nxt      = cmd_fill;
      back_nxt      = cmd_back;
      last_nxt      = cmd_last;
    end
  end

  assign rd_addr = base_r + tcgr_pkg::STORE_AW'(line_nxt);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[in_font_addr] <= in_font_byte;
    end
    rdata_r <= font_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcgr_pkg::ST_IDLE;
      text_col_r  <= 9'd0;
      text_row_r  <= 8'd0;
      cur_col_r   <= 9'd0;
      cur_row_r   <= 8'd0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      text_col_r  <= text_col_nxt;
      text_row_r  <= text_row_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    base_r <= base_nxt;
    kind_r <= kind_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    bits_r <= bits_nxt;
    fill_r <= fill_nxt;
    back_r <= back_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_command_kind = kind_r;
  assign out_pixel_x      = x_r;
  assign out_pixel_y      = y_r;
  assign out_row_bits     = bits_r;
  assign out_fill_color   = fill_r;
  assign out_back_color   = back_r;
  assign out_last_of_run  = last_r;

endmodule
